@@ hw/rtl/sem_pkg.sv @@
// Shared types and constants for the Sobel edge magnitude block.
// Used by the front end, the gradient queue and the magnitude back end.
// No dependencies.
`default_nettype none

package sem_pkg;

   // Fixed field widths
   localparam int PIXEL_BITS   = 8;
   localparam int DIM_BITS     = 12;
   localparam int COL_OUT_BITS = 11;
   localparam int GRAD_BITS    = 11;
   localparam int WSUM_BITS    = 10;
   localparam int PROD_BITS    = 20;
   localparam int ROOT_BITS    = 16;

   // Gradient queue
   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   // Register reset values and limits
   localparam logic [DIM_BITS-1:0]   WIDTH_RESET  = 12'd640;
   localparam logic [DIM_BITS-1:0]   HEIGHT_RESET = 12'd480;
   localparam logic [DIM_BITS-1:0]   MIN_DIM      = 12'd3;
   localparam logic [PIXEL_BITS-1:0] MAG_LIMIT    = 8'd255;
   localparam logic [ROOT_BITS-1:0]  MAG_LIMIT_SQ = 16'd65025;

   // Register indexes
   typedef enum logic {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // One gradient pair with the centre position, front to back
   typedef struct packed {
      logic signed [GRAD_BITS-1:0] gx;
      logic signed [GRAD_BITS-1:0] gy;
      logic [DIM_BITS-1:0]         row;
      logic [COL_OUT_BITS-1:0]     col;
      logic                        last;
   } grad_entry_type;

endpackage

`default_nettype wire

@@ hw/rtl/sobel_edge_magnitude.sv @@
// Sobel edge magnitude over a raster-order grayscale stream.
// Input channel req_*: one 8-bit pixel per transfer, tuser marks the first
// pixel of a frame and restarts the row and column counters.
// Result channel rsp_*: one transfer per interior pixel with the clamped
// integer gradient magnitude and the centre row and column; tlast is set
// on the last interior pixel of the frame. Border pixels give nothing.
// Configuration: csr_we/csr_index/csr_wdata write frame width (index 0)
// and frame height (index 1); write only while the block is idle.
// Flow: the front end reads the line stores as it accepts a pixel, then
// rotates them before it takes the next. The back end works on one interior
// result at a time (square, sum, 8 root steps one bit each, hand-over) and
// skips the root steps when the magnitude clamps to 255; this sets the
// sustained rate on interior pixels. A 4-entry gradient queue lets the
// front end run ahead of the back end.
// A stalled receiver holds the result; the queue fills and then req_tready
// falls. Reset clears counters, window, queue and registers (640 x 480);
// line stores are not cleared and need no clearing pass.
// Depends on sem_pkg, sem_front, sem_fifo and sem_back.
`default_nettype none

module sobel_edge_magnitude
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_we,
   input  wire logic                csr_index,
   input  wire logic [DIM_BITS-1:0] csr_wdata,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [7:0]          req_tdata,   // [7:0] pixel_value
   input  wire logic                req_tuser,   // [0] frame_start
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [31:0]              rsp_tdata,   // [7:0] edge_magnitude,
                                                 // [19:8] centre_row,
                                                 // [30:20] centre_col, [31] zero
   output logic                     rsp_tlast    // frame_done
);

   logic                     can_push;
   logic                     push_valid;
   grad_entry_type           push_entry;
   logic                     pop_valid;
   logic                     pop_ready;
   grad_entry_type           pop_entry;
   logic [PIXEL_BITS-1:0]    edge_magnitude;
   logic [DIM_BITS-1:0]      centre_row;
   logic [COL_OUT_BITS-1:0]  centre_col;

   sem_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .pixel_value (req_tdata[PIXEL_BITS-1:0]),
      .frame_start (req_tuser),
      .can_push    (can_push),
      .push_valid  (push_valid),
      .push_entry  (push_entry)
   );

   sem_fifo u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .can_push   (can_push),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   sem_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_ready      (pop_ready),
      .pop_entry      (pop_entry),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .edge_magnitude (edge_magnitude),
      .centre_row     (centre_row),
      .centre_col     (centre_col),
      .frame_done     (rsp_tlast)
   );

   // Result packing, first field lowest
   assign rsp_tdata = {1'b0, centre_col, centre_row, edge_magnitude};

endmodule

`default_nettype wire

@@ hw/rtl/sem_front.sv @@
// Front end: configuration registers, raster counters, line stores, window
// and Sobel kernels. Pushes one gradient entry per interior pixel.
// Depends on sem_pkg.
`default_nettype none

module sem_front
   import sem_pkg::*;
#(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_we,
   input  wire logic                  csr_index,
   input  wire logic [DIM_BITS-1:0]   csr_wdata,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [PIXEL_BITS-1:0] pixel_value,
   input  wire logic                  frame_start,
   input  wire logic                  can_push,
   output logic                       push_valid,
   output grad_entry_type             push_entry
);

   localparam int WCAP      = (MAX_WIDTH < 4095) ? MAX_WIDTH : 4095;
   localparam int COL_BITS  = $clog2(WCAP);
   localparam int ADDR_BITS = $clog2(MAX_WIDTH);
   localparam logic [DIM_BITS-1:0] WCAP_DIM = DIM_BITS'(WCAP);

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } front_state_type;

   front_state_type          state_ff;
   logic [DIM_BITS-1:0]      width_ff;
   logic [DIM_BITS-1:0]      height_ff;
   logic [COL_BITS-1:0]      col_ff, col_in;
   logic [DIM_BITS-1:0]      row_ff, row_in;
   logic                     emit_ff;
   logic [PIXEL_BITS-1:0]    win_ff [3][2];   // window columns 1 and 2

   logic [PIXEL_BITS-1:0]    pix_ff;
   logic [ADDR_BITS-1:0]     idx_ff;
   logic [PIXEL_BITS-1:0]    older_rd_ff;
   logic [PIXEL_BITS-1:0]    newer_rd_ff;
   logic [DIM_BITS-1:0]      centre_row_ff;
   logic [COL_OUT_BITS-1:0]  centre_col_ff;
   logic                     last_ff;

   logic [PIXEL_BITS-1:0]    older_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0]    newer_mem [MAX_WIDTH];

   logic                     accept;
   logic [DIM_BITS-1:0]      eff_w, eff_h;
   logic [COL_BITS-1:0]      col_cur;
   logic [DIM_BITS-1:0]      row_cur;
   logic [DIM_BITS-1:0]      col_dim;
   logic [ADDR_BITS-1:0]     idx_c;
   logic                     emit_c, last_c;
   logic [WSUM_BITS-1:0]     gx_pos, gx_neg, gy_pos, gy_neg;

   // 1-2-1 weighted sum of three pixels
   function automatic logic [WSUM_BITS-1:0] weigh(input logic [PIXEL_BITS-1:0] a,
                                                  input logic [PIXEL_BITS-1:0] b,
                                                  input logic [PIXEL_BITS-1:0] c);
      weigh = WSUM_BITS'(a) + {1'b0, b, 1'b0} + WSUM_BITS'(c);
   endfunction

   assign accept    = req_valid & req_ready;
   assign req_ready = (state_ff == ST_IDLE) & can_push;

   // Effective frame size
   always_comb begin
      eff_w = width_ff;
      if (width_ff < MIN_DIM) begin
         eff_w = MIN_DIM;
      end else if (width_ff > WCAP_DIM) begin
         eff_w = WCAP_DIM;
      end
      eff_h = (height_ff < MIN_DIM) ? MIN_DIM : height_ff;
   end

   // Position of the incoming pixel and the next counter values
   always_comb begin
      col_cur = frame_start ? '0 : col_ff;
      row_cur = frame_start ? '0 : row_ff;
      col_dim = DIM_BITS'(col_cur);
      idx_c   = ADDR_BITS'(col_cur);
      emit_c  = (row_cur >= 12'd2) && (col_dim >= 12'd2) && (col_dim < eff_w) &&
                (row_cur < eff_h);
      last_c  = (row_cur == eff_h - 12'd1) && (col_dim == eff_w - 12'd1);
      if (col_dim >= eff_w - 12'd1) begin
         col_in = '0;
         row_in = (row_cur >= eff_h - 12'd1) ? '0 : row_cur + 12'd1;
      end else begin
         col_in = col_cur + COL_BITS'(1);
         row_in = row_cur;
      end
   end

   // Kernels over the window after the shift: incoming column is
   // older row, newer row, pixel
   always_comb begin
      gx_pos = weigh(older_rd_ff, newer_rd_ff, pix_ff);
      gx_neg = weigh(win_ff[0][0], win_ff[1][0], win_ff[2][0]);
      gy_pos = weigh(win_ff[2][0], win_ff[2][1], pix_ff);
      gy_neg = weigh(win_ff[0][0], win_ff[0][1], older_rd_ff);
   end

   assign push_valid      = (state_ff == ST_UPDATE) & emit_ff;
   assign push_entry.gx   = $signed({1'b0, gx_pos}) - $signed({1'b0, gx_neg});
   assign push_entry.gy   = $signed({1'b0, gy_pos}) - $signed({1'b0, gy_neg});
   assign push_entry.row  = centre_row_ff;
   assign push_entry.col  = centre_col_ff;
   assign push_entry.last = last_ff;

   // Control state, registers, counters and window
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
         col_ff    <= '0;
         row_ff    <= '0;
         emit_ff   <= 1'b0;
         for (int r = 0; r < 3; r++) begin
            win_ff[r][0] <= '0;
            win_ff[r][1] <= '0;
         end
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  state_ff <= ST_UPDATE;
                  col_ff   <= col_in;
                  row_ff   <= row_in;
                  emit_ff  <= emit_c;
               end
            end
            ST_UPDATE: begin
               state_ff     <= ST_IDLE;
               win_ff[0][0] <= win_ff[0][1];
               win_ff[1][0] <= win_ff[1][1];
               win_ff[2][0] <= win_ff[2][1];
               win_ff[0][1] <= older_rd_ff;
               win_ff[1][1] <= newer_rd_ff;
               win_ff[2][1] <= pix_ff;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // Payload of the pixel in flight
   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff        <= pixel_value;
         idx_ff        <= idx_c;
         centre_row_ff <= row_cur - 12'd1;
         centre_col_ff <= COL_OUT_BITS'(col_dim - 12'd1);
         last_ff       <= last_c;
      end
   end

   // Line stores: read at acceptance, rotate in the next cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         older_rd_ff <= older_mem[idx_c];
         newer_rd_ff <= newer_mem[idx_c];
      end
      if (state_ff == ST_UPDATE) begin
         older_mem[idx_ff] <= newer_rd_ff;
         newer_mem[idx_ff] <= pix_ff;
      end
   end

   // A pixel always takes the update cycle before the next transfer
   a_update_follows: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_UPDATE) && !req_ready)
      else $error("front accepted a pixel without its update cycle");

endmodule

`default_nettype wire

@@ hw/rtl/sem_fifo.sv @@
// Short gradient queue between front and back end.
// Depends on sem_pkg.
`default_nettype none

module sem_fifo
   import sem_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            push_valid,
   input  wire grad_entry_type  push_entry,
   output logic                 can_push,
   output logic                 pop_valid,
   input  wire logic            pop_ready,
   output grad_entry_type       pop_entry
);

   grad_entry_type              slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_BITS:0]     count_ff;
   logic                        pop;

   assign can_push  = (count_ff < (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid & pop_ready;
   assign pop_entry = slot_ff[rd_ptr_ff];

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) begin
            wr_ptr_ff <= wr_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QUEUE_PTR_BITS'(1);
         end
         case ({push_valid, pop})
            2'b10:   count_ff <= count_ff + (QUEUE_PTR_BITS + 1)'(1);
            2'b01:   count_ff <= count_ff - (QUEUE_PTR_BITS + 1)'(1);
            default: count_ff <= count_ff;
         endcase
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push_valid) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_valid |-> (count_ff < (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH)) || pop)
      else $error("gradient queue written while full");

   a_level_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("gradient queue level out of range");

endmodule

`default_nettype wire

@@ hw/rtl/sem_back.sv @@
// Back end: squares the gradients, clamps, and takes an 8-bit integer
// square root one result bit per cycle. Holds the result until taken.
// Depends on sem_pkg.
`default_nettype none

module sem_back
   import sem_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   pop_valid,
   output logic                        pop_ready,
   input  wire grad_entry_type         pop_entry,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [PIXEL_BITS-1:0]       edge_magnitude,
   output logic [DIM_BITS-1:0]         centre_row,
   output logic [COL_OUT_BITS-1:0]     centre_col,
   output logic                        frame_done
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_SUM,
      B_ROOT,
      B_OUT
   } back_state_type;

   back_state_type             state_ff;
   logic [PROD_BITS-1:0]       prod_x_ff, prod_y_ff;
   logic [DIM_BITS-1:0]        row_ff;
   logic [COL_OUT_BITS-1:0]    col_ff;
   logic                       last_ff;
   logic [ROOT_BITS-1:0]       rem_ff, rem_in;
   logic [ROOT_BITS-1:0]       root_ff, root_in;
   logic [2:0]                 step_ff;
   logic [PIXEL_BITS-1:0]      mag_ff;

   logic signed [2*GRAD_BITS-1:0] sq_x, sq_y;
   logic [PROD_BITS:0]         sum_sq;
   logic [ROOT_BITS-1:0]       bit_mask;
   logic [ROOT_BITS:0]         trial;

   assign pop_ready = (state_ff == B_IDLE);

   assign sq_x   = $signed(pop_entry.gx) * $signed(pop_entry.gx);
   assign sq_y   = $signed(pop_entry.gy) * $signed(pop_entry.gy);
   assign sum_sq = {1'b0, prod_x_ff} + {1'b0, prod_y_ff};

   // One restoring square-root step
   always_comb begin
      bit_mask = ROOT_BITS'(1) << {step_ff, 1'b0};
      trial    = {1'b0, root_ff} + {1'b0, bit_mask};
      if ({1'b0, rem_ff} >= trial) begin
         rem_in  = rem_ff - trial[ROOT_BITS-1:0];
         root_in = (root_ff >> 1) + bit_mask;
      end else begin
         rem_in  = rem_ff;
         root_in = root_ff >> 1;
      end
   end

   assign rsp_valid      = (state_ff == B_OUT);
   assign edge_magnitude = mag_ff;
   assign centre_row     = row_ff;
   assign centre_col     = col_ff;
   assign frame_done     = last_ff;

   // Sequencer and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         case (state_ff)
            B_IDLE: begin
               if (pop_valid) begin
                  state_ff <= B_SUM;
               end
            end
            B_SUM: begin
               if (sum_sq >= (PROD_BITS + 1)'(MAG_LIMIT_SQ)) begin
                  state_ff <= B_OUT;
               end else begin
                  state_ff <= B_ROOT;
               end
            end
            B_ROOT: begin
               if (step_ff == 3'd0) begin
                  state_ff <= B_OUT;
               end
            end
            B_OUT: begin
               if (rsp_ready) begin
                  state_ff <= B_IDLE;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               prod_x_ff <= sq_x[PROD_BITS-1:0];
               prod_y_ff <= sq_y[PROD_BITS-1:0];
               row_ff    <= pop_entry.row;
               col_ff    <= pop_entry.col;
               last_ff   <= pop_entry.last;
            end
         end
         B_SUM: begin
            mag_ff  <= MAG_LIMIT;
            rem_ff  <= sum_sq[ROOT_BITS-1:0];
            root_ff <= '0;
            step_ff <= 3'd7;
         end
         B_ROOT: begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            step_ff <= step_ff - 3'd1;
            if (step_ff == 3'd0) begin
               mag_ff <= root_in[PIXEL_BITS-1:0];
            end
         end
         default: ;
      endcase
   end

   a_root_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_ROOT) && (step_ff == 3'd0) |=> rsp_valid)
      else $error("square root did not finish after its last step");

endmodule

`default_nettype wire

@@ tb/sobel_edge_magnitude_tb.sv @@
// Self-checking testbench for the Sobel edge magnitude block.
// Streams raster-order pixel frames at several frame sizes and checks every result
// against an in-bench line-store and window predictor. Depends on sem_pkg and the RTL.
module sobel_edge_magnitude_tb;
   import sem_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_LINE      = 2048;
   localparam int SETTLE_CYCLES = 40;
   localparam int QUIET_LIMIT   = 5000;
   localparam int PHASE_PIXELS  = 75;
   localparam int WIDE_PIXELS   = 64;
   localparam int TALL_ROWS     = 24;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
   typedef enum {TEXTURE_NOISE, TEXTURE_HARD, TEXTURE_FLAT} texture_t;

   typedef struct packed {
      logic [PIXEL_BITS-1:0] value;
      logic                  start;
   } pixel_item_t;

   typedef struct packed {
      logic [PIXEL_BITS-1:0]   magnitude;
      logic [DIM_BITS-1:0]     row;
      logic [COL_OUT_BITS-1:0] col;
      logic                    done;
   } edge_result_t;

   // Block ports
   logic                  clock;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   csr_index_type         csr_index = CSR_FRAME_WIDTH;
   logic [DIM_BITS-1:0]   csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;   // [7:0] pixel_value
   logic                  req_tuser = 1'b0; // [0] frame_start
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [31:0]           rsp_tdata;        // [7:0] magnitude, [19:8] row, [30:20] col
   logic                  rsp_tlast;        // frame_done

   // Stimulus and scoreboard
   pixel_item_t  pixel_backlog[$];
   edge_result_t pending_edges[$];
   idle_mode_t   idle_mode = IDLE_NONE;
   logic         req_fire = 1'b0;
   int           quiet_cycles = 0;
   int           mismatches = 0;
   int           pixels_sent = 0;
   int           edges_checked = 0;
   int           frames_closed = 0;
   int           size_settings = 0;

   // Predictor state
   logic [DIM_BITS-1:0]     width_reg = WIDTH_RESET;
   logic [DIM_BITS-1:0]     height_reg = HEIGHT_RESET;
   logic [PIXEL_BITS-1:0]   older_row [MAX_LINE];
   logic [PIXEL_BITS-1:0]   newer_row [MAX_LINE];
   logic [PIXEL_BITS-1:0]   win [3][3];
   logic [COL_OUT_BITS-1:0] col_count = '0;
   logic [DIM_BITS-1:0]     row_count = '0;

   sobel_edge_magnitude dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic int eff_width(logic [DIM_BITS-1:0] value);
      if (value < MIN_DIM) return MIN_DIM;
      if (value > MAX_LINE) return MAX_LINE;
      return value;
   endfunction

   function automatic int eff_height(logic [DIM_BITS-1:0] value);
      return (value < MIN_DIM) ? MIN_DIM : int'(value);
   endfunction

   // Shift the window, update the line stores, queue a result for interior centres
   function automatic void predict_edge(logic [PIXEL_BITS-1:0] pixel, logic start);
      int w, h, left, right, top, bottom, gx, gy, ss, root;
      logic [COL_OUT_BITS-1:0] col;
      logic [DIM_BITS-1:0] row;
      edge_result_t res;
      w = eff_width(width_reg);
      h = eff_height(height_reg);
      if (start) begin
         col_count = '0;
         row_count = '0;
      end
      col = col_count;
      row = row_count;
      for (int r = 0; r < 3; r++) begin
         win[r][0] = win[r][1];
         win[r][1] = win[r][2];
      end
      win[0][2] = older_row[col];
      win[1][2] = newer_row[col];
      win[2][2] = pixel;
      older_row[col] = newer_row[col];
      newer_row[col] = pixel;

      if (row >= 2 && col >= 2 && col < w && row < h) begin
         left   = win[0][0] + 2 * win[1][0] + win[2][0];
         right  = win[0][2] + 2 * win[1][2] + win[2][2];
         top    = win[0][0] + 2 * win[0][1] + win[0][2];
         bottom = win[2][0] + 2 * win[2][1] + win[2][2];
         gx = right - left;
         gy = bottom - top;
         ss = gx * gx + gy * gy;
         if (ss >= MAG_LIMIT_SQ) begin
            root = MAG_LIMIT;
         end else begin
            root = 0;
            while ((root + 1) * (root + 1) <= ss) root++;
         end
         res.magnitude = PIXEL_BITS'(root);
         res.row       = row - 1'b1;
         res.col       = col - 1'b1;
         res.done      = (row == h - 1) && (col == w - 1);
         pending_edges.push_back(res);
      end

      // Row and frame wrap
      if (col >= w - 1) begin
         col_count = '0;
         row_count = (row >= h - 1) ? '0 : row + 1'b1;
      end else begin
         col_count = col + 1'b1;
      end
   endfunction

   // Idle roll for one side of the handshake
   function automatic bit stall_roll(idle_mode_t own);
      if (idle_mode == own) return $urandom_range(0, 99) < 53;
      if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 38;
      return 1'b0;
   endfunction

   // Driver: present the next pixel once the current one has been taken
   always @(negedge clock) begin
      pixel_item_t next_pixel;
      if (!req_tvalid || req_fire) begin
         if (pixel_backlog.size() != 0 && !stall_roll(IDLE_SENDER)) begin
            next_pixel = pixel_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= next_pixel.value;
            req_tuser  <= next_pixel.start;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      rsp_tready <= !stall_roll(IDLE_RECEIVER);
   end

   // Monitor: predict on each pixel transfer, check each result transfer
   always @(posedge clock) begin
      edge_result_t got, want;
      if (reset) begin
         req_fire <= 1'b0;
         quiet_cycles = 0;
      end else begin
         req_fire <= req_tvalid && req_tready;
         if (req_tvalid && req_tready) begin
            predict_edge(req_tdata, req_tuser);
            pixels_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.magnitude = rsp_tdata[7:0];
            got.row       = rsp_tdata[19:8];
            got.col       = rsp_tdata[30:20];
            got.done      = rsp_tlast;
            edges_checked++;
            if (got.done === 1'b1) frames_closed++;
            if (pending_edges.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected result mag %0d row %0d col %0d done %0b",
                           $realtime, got.magnitude, got.row, got.col, got.done);
            end else begin
               want = pending_edges.pop_front();
               if (got.magnitude !== want.magnitude || got.row !== want.row ||
                   got.col !== want.col || got.done !== want.done) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"%0t: result differs: expected mag %0d row %0d col %0d ",
                               "done %0b, got mag %0d row %0d col %0d done %0b"},
                              $realtime, want.magnitude, want.row, want.col, want.done,
                              got.magnitude, got.row, got.col, got.done);
               end
            end
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_edges.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   task automatic push_pixel(logic [PIXEL_BITS-1:0] value, logic start);
      pixel_item_t item;
      item.value = value;
      item.start = start;
      pixel_backlog.push_back(item);
   endtask

   // A run of pixels with one texture; start marks only the first
   task automatic queue_pixels(int count, bit start);
      texture_t texture;
      int base;
      logic [PIXEL_BITS-1:0] value;
      texture = texture_t'($urandom_range(0, 2));
      base = $urandom_range(0, 240);
      for (int i = 0; i < count; i++) begin
         case (texture)
            TEXTURE_NOISE: value = PIXEL_BITS'($urandom_range(0, 255));
            TEXTURE_HARD:  value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:       value = PIXEL_BITS'(base + $urandom_range(0, 15));
         endcase
         push_pixel(value, start && (i == 0));
      end
   endtask

   // Mostly whole frames; some cut short by the next frame start, some with no start
   task automatic queue_frames(int w, int h, int budget);
      int queued, n;
      bit start;
      queued = 0;
      while (queued < budget) begin
         n = w * h;
         start = 1'b1;
         case ($urandom_range(0, 9))
            0: n = $urandom_range(1, w * h - 1);
            1: start = (queued == 0);
            default: ;
         endcase
         queue_pixels(n, start);
         queued += n;
      end
   endtask

   task automatic write_csr(csr_index_type index, logic [DIM_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == CSR_FRAME_WIDTH)
         width_reg = value;
      else
         height_reg = value;
   endtask

   task automatic set_frame_size(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
      write_csr(CSR_FRAME_WIDTH, w);
      write_csr(CSR_FRAME_HEIGHT, h);
      size_settings++;
   endtask

   // Wait for every pixel to go in and every result to come out
   task automatic settle();
      while (pixel_backlog.size() != 0 || req_tvalid || pending_edges.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [DIM_BITS-1:0] wreg, hreg;
      for (int i = 0; i < MAX_LINE; i++) begin
         older_row[i] = '0;
         newer_row[i] = '0;
      end
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            win[r][c] = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zero registers clamp to 3 x 3
      idle_mode = IDLE_NONE;
      set_frame_size('0, '0);
      // Hard vertical edge, magnitude clamps
      for (int r = 0; r < 3; r++)
         for (int c = 0; c < 3; c++)
            push_pixel((c == 0) ? 8'h00 : (c == 1) ? 8'h80 : 8'hFF, r == 0 && c == 0);
      // Shallow horizontal step, no frame start: the counters wrapped on their own
      for (int i = 0; i < 9; i++)
         push_pixel((i < 6) ? 8'd10 : 8'd13, 1'b0);
      // Frame cut short by the next frame start
      for (int i = 0; i < 4; i++)
         push_pixel(8'hFF, i == 0);
      settle();

      // Random small frames under each idling pattern
      for (int m = 0; m < 4; m++) begin
         idle_mode = idle_mode_t'(m);
         wreg = ($urandom_range(0, 4) == 0) ? DIM_BITS'($urandom_range(0, 2))
                                            : DIM_BITS'($urandom_range(3, 14));
         hreg = ($urandom_range(0, 4) == 0) ? DIM_BITS'($urandom_range(0, 2))
                                            : DIM_BITS'($urandom_range(3, 9));
         set_frame_size(wreg, hreg);
         queue_frames(eff_width(wreg), eff_height(hreg), PHASE_PIXELS);
         settle();
      end

      // Size shrunk mid-frame: counters past the new width wrap at the next pixel
      idle_mode = IDLE_BOTH;
      set_frame_size(12'd10, 12'd6);
      queue_pixels(60, 1'b1);
      queue_pixels(38, 1'b0);
      settle();
      set_frame_size(12'd5, 12'd5);
      queue_pixels(40, 1'b0);
      queue_frames(5, 5, 60);
      settle();

      // Oversized width register: a short run stays within the first row
      idle_mode = IDLE_RECEIVER;
      set_frame_size(12'hFFF, 12'd3);
      queue_pixels(WIDE_PIXELS, 1'b1);
      settle();

      // Tall frame at minimum width, cut after a few rows
      idle_mode = IDLE_SENDER;
      set_frame_size(12'd3, 12'hFFF);
      queue_pixels(3 * TALL_ROWS, 1'b1);
      settle();

      $display("Covered %0d frame size settings, from registers below 3 up to oversized",
               size_settings);
      $display("width and height; %0d pixels in, %0d edge results checked, %0d frame ends",
               pixels_sent, edges_checked, frames_closed);
      if (mismatches == 0 && pending_edges.size() == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/sem_pkg.sv
hw/rtl/sem_front.sv
hw/rtl/sem_fifo.sv
hw/rtl/sem_back.sv
hw/rtl/sobel_edge_magnitude.sv
tb/sobel_edge_magnitude_tb.sv
